FILE: rtl/core/ibc_pkg.sv
// shared types, constants and register map of the imu bias calibrator
package ibc_pkg;

    // sample and accumulator widths
    localparam int DATA_W    = 16;
    localparam int SUM_W     = 26;
    localparam int CNT_W     = 10;
    localparam int LEFT_W    = 8;
    localparam int AXES      = 6;
    localparam int GYRO_AXES = 3;
    localparam int ACCEL_Z   = 5;
    localparam int PHASE_W   = 2;

    // averaging window length
    localparam int AVG_SAMPLES = 255;

    // reciprocal for the window division, exact for any magnitude below 2**SUM_W
    localparam int DIV_L   = $clog2(AVG_SAMPLES);
    localparam int DIV_SH  = SUM_W + DIV_L;
    localparam int MULT_W  = SUM_W + 2;
    localparam int PROD_W  = DIV_SH + SUM_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    // configuration register map
    localparam int REG_IDX_W = 2;
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int APB_W     = 32;
    localparam logic [REG_IDX_W-1:0] REG_STILL_THR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STILL_CNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY   = 2'd2;

    // register reset values
    localparam logic [DATA_W-1:0]        THR_RESET     = 16'd10;
    localparam logic [LEFT_W-1:0]        CNT_RESET     = 8'd30;
    localparam logic signed [DATA_W-1:0] GRAVITY_RESET = 16'sd16383;

    // calibration phase
    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT = 2'd0,
        PH_AVG  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    // per-stage commands from the controller to every lane
    typedef struct packed {
        logic load1;
        logic clear;
        logic accum;
        logic finish;
        logic prev_load;
        logic load2;
        logic load3;
        logic set_offs;
        logic use_offs;
    } lane_ctl_t;

endpackage

FILE: rtl/core/ibc_lane.sv
// one axis lane: stillness compare, window accumulator, reciprocal divide, correction
module ibc_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ibc_pkg::lane_ctl_t                   ctl,
    input  logic signed [ibc_pkg::DATA_W-1:0]    sample,
    input  logic signed [ibc_pkg::DATA_W-1:0]    bias,
    input  logic        [ibc_pkg::DATA_W-1:0]    still_thr,
    output logic                                 still,
    output logic signed [ibc_pkg::DATA_W-1:0]    corr
);

    logic signed [ibc_pkg::DATA_W-1:0] prev_reg;
    logic signed [ibc_pkg::DATA_W:0]   diff;
    logic        [ibc_pkg::DATA_W:0]   diff_abs;
    logic signed [ibc_pkg::DATA_W:0]   val;
    logic        [ibc_pkg::SUM_W-1:0]  sum_reg;
    logic        [ibc_pkg::SUM_W-1:0]  sum_next;
    logic        [ibc_pkg::SUM_W-1:0]  mag;
    logic        [ibc_pkg::PROD_W-1:0] prod;

    logic signed [ibc_pkg::DATA_W-1:0] smp1_reg;
    logic        [ibc_pkg::SUM_W-1:0]  mag1_reg;
    logic                              sign1_reg;
    logic signed [ibc_pkg::DATA_W-1:0] smp2_reg;
    logic        [ibc_pkg::SUM_W-1:0]  q2_reg;
    logic                              sign2_reg;
    logic signed [ibc_pkg::DATA_W-1:0] offs_reg;
    logic signed [ibc_pkg::DATA_W-1:0] corr_reg;

    // change against the previous sample
    assign diff     = (ibc_pkg::DATA_W+1)'(sample) - (ibc_pkg::DATA_W+1)'(prev_reg);
    assign diff_abs = diff[ibc_pkg::DATA_W] ? (ibc_pkg::DATA_W+1)'(-diff)
                                            : (ibc_pkg::DATA_W+1)'(diff);
    assign still    = (diff_abs <= {1'b0, still_thr});

    // running sum with the lane reference removed, and its magnitude
    assign val      = (ibc_pkg::DATA_W+1)'(sample) - (ibc_pkg::DATA_W+1)'(bias);
    assign sum_next = sum_reg + ibc_pkg::SUM_W'(val);
    assign mag      = sum_next[ibc_pkg::SUM_W-1] ? (-sum_next) : sum_next;

    // divide by the window length through the reciprocal
    assign prod = ibc_pkg::PROD_W'(mag1_reg) * ibc_pkg::PROD_W'(ibc_pkg::DIV_MULT);

    // accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctl.clear || ctl.finish)
        begin
            sum_reg <= '0;
        end
        else if (ctl.accum)
        begin
            sum_reg <= sum_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (ctl.prev_load)
        begin
            prev_reg <= sample;
        end
        if (ctl.load1)
        begin
            smp1_reg  <= sample;
            mag1_reg  <= mag;
            sign1_reg <= sum_next[ibc_pkg::SUM_W-1];
        end
        if (ctl.load2)
        begin
            smp2_reg  <= smp1_reg;
            q2_reg    <= prod[ibc_pkg::DIV_SH +: ibc_pkg::SUM_W];
            sign2_reg <= sign1_reg;
        end
        if (ctl.set_offs)
        begin
            offs_reg <= sign2_reg ? (-q2_reg[ibc_pkg::DATA_W-1:0])
                                  : q2_reg[ibc_pkg::DATA_W-1:0];
        end
        if (ctl.load3)
        begin
            corr_reg <= smp2_reg - (ctl.use_offs ? offs_reg : '0);
        end
    end

    assign corr = corr_reg;

endmodule

FILE: rtl/core/ibc_ctrl.sv
// calibration phase control, stage handshake and configuration registers
module ibc_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   recal,
    input  logic [ibc_pkg::GYRO_AXES-1:0]          still,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ibc_pkg::PHASE_W-1:0]            out_phase,
    output ibc_pkg::lane_ctl_t                     ctl,
    output logic        [ibc_pkg::DATA_W-1:0]      still_thr,
    output logic signed [ibc_pkg::DATA_W-1:0]      gravity,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ibc_pkg::ADDR_W-1:0]             paddr,
    input  logic [ibc_pkg::APB_W-1:0]              pwdata,
    output logic [ibc_pkg::APB_W-1:0]              prdata
);

    ibc_pkg::phase_t                    phase_reg, phase_next, ph_eff;
    logic                               have_prev_reg, hp_eff, hp_next;
    logic [ibc_pkg::LEFT_W-1:0]         left_reg, left_eff, left_next;
    logic [ibc_pkg::CNT_W-1:0]          cnt_reg, cnt_eff, cnt_next, cnt_inc;
    logic                               complete;

    logic [ibc_pkg::DATA_W-1:0]         thr_reg;
    logic [ibc_pkg::LEFT_W-1:0]         still_cnt_reg;
    logic signed [ibc_pkg::DATA_W-1:0]  grav_reg;
    logic                               wr;
    logic [ibc_pkg::REG_IDX_W-1:0]      idx;

    logic                               v1_reg, v2_reg, v3_reg;
    ibc_pkg::phase_t                    ph1_reg, ph2_reg, ph3_reg;
    logic                               done1_reg, done2_reg;
    logic                               adv1, adv2, adv3, ready2, ready3;

    // elastic stage handshake, each stage holds its own request
    assign ready3   = !v3_reg || out_ready;
    assign adv3     = v2_reg && ready3;
    assign ready2   = !v2_reg || ready3;
    assign adv2     = v1_reg && ready2;
    assign in_ready = !v1_reg || ready2;
    assign adv1     = in_valid && in_ready;

    // next calibration state for the request at the input
    always_comb
    begin
        ph_eff     = recal ? ibc_pkg::PH_WAIT : phase_reg;
        hp_eff     = recal ? 1'b0 : have_prev_reg;
        left_eff   = recal ? still_cnt_reg : left_reg;
        cnt_eff    = recal ? '0 : cnt_reg;
        phase_next = ph_eff;
        hp_next    = hp_eff;
        left_next  = left_eff;
        cnt_inc    = cnt_eff + 1'b1;
        cnt_next   = cnt_eff;
        complete   = 1'b0;
        case (ph_eff)
            ibc_pkg::PH_WAIT:
            begin
                hp_next = 1'b1;
                if (hp_eff && (&still) && (left_eff != '0))
                begin
                    left_next = left_eff - 1'b1;
                end
                if (left_next == '0)
                begin
                    phase_next = ibc_pkg::PH_AVG;
                end
            end
            ibc_pkg::PH_AVG:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= ibc_pkg::CNT_W'(ibc_pkg::AVG_SAMPLES))
                begin
                    complete   = 1'b1;
                    cnt_next   = '0;
                    phase_next = ibc_pkg::PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // lane commands
    always_comb
    begin
        ctl.load1     = adv1;
        ctl.clear     = adv1 && recal;
        ctl.accum     = adv1 && (ph_eff == ibc_pkg::PH_AVG);
        ctl.finish    = adv1 && (ph_eff == ibc_pkg::PH_AVG) && complete;
        ctl.prev_load = adv1 && (ph_eff == ibc_pkg::PH_WAIT);
        ctl.load2     = adv2;
        ctl.load3     = adv3;
        ctl.set_offs  = adv3 && done2_reg;
        ctl.use_offs  = (ph2_reg == ibc_pkg::PH_DONE);
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ibc_pkg::PH_WAIT;
            have_prev_reg <= 1'b0;
            left_reg      <= ibc_pkg::CNT_RESET;
            cnt_reg       <= '0;
        end
        else if (wr && (idx == ibc_pkg::REG_STILL_CNT))
        begin
            left_reg <= pwdata[ibc_pkg::LEFT_W-1:0];
        end
        else if (adv1)
        begin
            phase_reg     <= phase_next;
            have_prev_reg <= hp_next;
            left_reg      <= left_next;
            cnt_reg       <= cnt_next;
        end
    end

    // stage valids and per-request tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            ph1_reg   <= ibc_pkg::PH_WAIT;
            ph2_reg   <= ibc_pkg::PH_WAIT;
            ph3_reg   <= ibc_pkg::PH_WAIT;
            done1_reg <= 1'b0;
            done2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg    <= 1'b1;
                ph1_reg   <= ph_eff;
                done1_reg <= ctl.finish;
            end
            else if (adv2)
            begin
                v1_reg <= 1'b0;
            end
            if (adv2)
            begin
                v2_reg    <= 1'b1;
                ph2_reg   <= ph1_reg;
                done2_reg <= done1_reg;
            end
            else if (adv3)
            begin
                v2_reg <= 1'b0;
            end
            if (adv3)
            begin
                v3_reg  <= 1'b1;
                ph3_reg <= ph2_reg;
            end
            else if (out_ready)
            begin
                v3_reg <= 1'b0;
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_phase = ph3_reg;

    // configuration registers
    assign wr  = psel && penable && pwrite;
    assign idx = paddr[ibc_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= ibc_pkg::THR_RESET;
            still_cnt_reg <= ibc_pkg::CNT_RESET;
            grav_reg      <= ibc_pkg::GRAVITY_RESET;
        end
        else if (wr)
        begin
            case (idx)
                ibc_pkg::REG_STILL_THR: thr_reg       <= pwdata[ibc_pkg::DATA_W-1:0];
                ibc_pkg::REG_STILL_CNT: still_cnt_reg <= pwdata[ibc_pkg::LEFT_W-1:0];
                ibc_pkg::REG_GRAVITY:   grav_reg      <= pwdata[ibc_pkg::DATA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (idx)
            ibc_pkg::REG_STILL_THR: prdata = ibc_pkg::APB_W'(thr_reg);
            ibc_pkg::REG_STILL_CNT: prdata = ibc_pkg::APB_W'(still_cnt_reg);
            ibc_pkg::REG_GRAVITY:   prdata = ibc_pkg::APB_W'(unsigned'(grav_reg));
            default:                prdata = '0;
        endcase
    end

    assign still_thr = thr_reg;
    assign gravity   = grav_reg;

endmodule

FILE: rtl/core/imu_bias_calibrator.sv
// top level of the six-axis imu bias calibrator
// One sample is taken every clock cycle unless the output stalls; its corrected result passes
// through two working stages and an output register, each of which holds its own request so
// that input keeps flowing while a result waits at the output. Six identical axis lanes run
// side by side: each compares its sample change for the stillness check, sums the averaging
// window, and turns the window sum into an offset with a reciprocal multiply over two stages;
// a shared controller merges the three stillness flags and steps the phase (wait for
// stillness, average, calibrated). Results carry the offsets and phase in force when their
// sample arrived, so the sample that closes the window still reads phase 1 and zero offsets.
module imu_bias_calibrator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_accel_x, raw_accel_y, raw_accel_z
    input  logic [ibc_pkg::AXES*ibc_pkg::DATA_W-1:0] s_axis_tdata,
    // recalibrate
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // corr_gyro_x, corr_gyro_y, corr_gyro_z, corr_accel_x, corr_accel_y, corr_accel_z
    output logic [ibc_pkg::AXES*ibc_pkg::DATA_W-1:0] m_axis_tdata,
    // calib_phase
    output logic [ibc_pkg::PHASE_W-1:0]       m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ibc_pkg::ADDR_W-1:0]        paddr,
    input  logic [ibc_pkg::APB_W-1:0]         pwdata,
    output logic [ibc_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);

    ibc_pkg::lane_ctl_t                 ctl;
    logic [ibc_pkg::AXES-1:0]           lane_still;
    logic        [ibc_pkg::DATA_W-1:0]  still_thr;
    logic signed [ibc_pkg::DATA_W-1:0]  gravity;

    assign pready = 1'b1;

    // phase control and configuration
    ibc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .recal     (s_axis_tuser),
        .still     (lane_still[ibc_pkg::GYRO_AXES-1:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_phase (m_axis_tuser),
        .ctl       (ctl),
        .still_thr (still_thr),
        .gravity   (gravity),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata)
    );

    // one lane per axis, gravity removed on accel z only
    for (genvar g = 0; g < ibc_pkg::AXES; g++)
    begin : g_lane
        logic signed [ibc_pkg::DATA_W-1:0] bias;
        logic signed [ibc_pkg::DATA_W-1:0] corr;

        assign bias = (g == ibc_pkg::ACCEL_Z) ? gravity : '0;

        ibc_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .sample    (s_axis_tdata[g*ibc_pkg::DATA_W +: ibc_pkg::DATA_W]),
            .bias      (bias),
            .still_thr (still_thr),
            .still     (lane_still[g]),
            .corr      (corr)
        );

        assign m_axis_tdata[g*ibc_pkg::DATA_W +: ibc_pkg::DATA_W] = corr;
    end

    // an empty output register always leaves room for a new request
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // a presented result never carries the unused phase code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ibc_pkg::PH_DONE))
        else $error("invalid calibration phase on output");

    // a waiting result stays presented and unchanged until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result dropped or changed while waiting");

endmodule

FILE: sim/tb.sv
// self-checking testbench for the imu bias calibrator: stream stimulus, apb setup, scoreboard
import ibc_pkg::*;

typedef struct packed {
    logic                        recal;
    logic [AXES-1:0][DATA_W-1:0] axis;
} imu_sample_t;

typedef struct packed {
    logic [PHASE_W-1:0]          phase;
    logic [AXES-1:0][DATA_W-1:0] axis;
} imu_corr_t;

// predicts corrected samples and calibration phase, then checks what comes out
class bias_scoreboard;
    logic [DATA_W-1:0]        thr_reg;
    logic [LEFT_W-1:0]        cnt_reg;
    logic signed [DATA_W-1:0] grav_reg;
    phase_t                   phase;
    bit                       have_prev;
    logic signed [DATA_W-1:0] prev_gyro [GYRO_AXES];
    logic [LEFT_W-1:0]        still_left;
    logic [CNT_W-1:0]         n_summed;
    logic signed [SUM_W-1:0]  axis_sum [AXES];
    logic signed [DATA_W-1:0] axis_offs [AXES];
    imu_corr_t                corr_q [$];
    int                       n_noted;
    int                       n_checked;
    int                       n_fail;
    int                       n_writes;
    int                       n_calibrated;

    function new();
        thr_reg  = THR_RESET;
        cnt_reg  = CNT_RESET;
        grav_reg = GRAVITY_RESET;
        restart();
    endfunction

    // back to waiting for stillness with offsets cleared
    function void restart();
        phase      = PH_WAIT;
        have_prev  = 0;
        still_left = cnt_reg;
        n_summed   = '0;
        for (int i = 0; i < GYRO_AXES; i++)
        begin
            prev_gyro[i] = '0;
        end
        for (int i = 0; i < AXES; i++)
        begin
            axis_sum[i]  = '0;
            axis_offs[i] = '0;
        end
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_W-1:0] val);
        n_writes++;
        case (idx)
            REG_STILL_THR: thr_reg = val[DATA_W-1:0];
            REG_STILL_CNT:
            begin
                cnt_reg    = val[LEFT_W-1:0];
                still_left = cnt_reg;
            end
            REG_GRAVITY:   grav_reg = val[DATA_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return corr_q.size();
    endfunction

    task report(string what);
        $display("MISMATCH: %s", what);
        n_fail++;
    endtask

    // one accepted sample: queue its corrected result, then advance calibration
    function void note_sample(imu_sample_t smp);
        imu_corr_t want;
        int        d;
        int        v;
        bit        still;
        longint    q;
        n_noted++;
        if (smp.recal)
            restart();
        for (int i = 0; i < AXES; i++)
        begin
            want.axis[i] = smp.axis[i] - axis_offs[i];
        end
        want.phase = phase;
        corr_q.push_back(want);
        case (phase)
            PH_WAIT:
            begin
                // first sample after a restart only primes the previous gyro
                if (!have_prev)
                    have_prev = 1;
                else
                begin
                    still = 1;
                    for (int i = 0; i < GYRO_AXES; i++)
                    begin
                        d = int'($signed(smp.axis[i])) - int'(prev_gyro[i]);
                        if (d < 0)
                            d = -d;
                        if (d > int'(thr_reg))
                            still = 0;
                    end
                    if (still && still_left != 0)
                        still_left--;
                end
                for (int i = 0; i < GYRO_AXES; i++)
                begin
                    prev_gyro[i] = smp.axis[i];
                end
                if (still_left == 0)
                    phase = PH_AVG;
            end
            PH_AVG:
            begin
                // accumulate the window, accel z taken relative to the gravity register
                for (int i = 0; i < AXES; i++)
                begin
                    v = int'($signed(smp.axis[i]));
                    if (i == ACCEL_Z)
                        v = v - int'(grav_reg);
                    axis_sum[i] = axis_sum[i] + SUM_W'(v);
                end
                n_summed++;
                if (n_summed >= AVG_SAMPLES)
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        q            = longint'(axis_sum[i]);
                        q            = q / AVG_SAMPLES;
                        axis_offs[i] = q[DATA_W-1:0];
                        axis_sum[i]  = '0;
                    end
                    n_summed = '0;
                    phase    = PH_DONE;
                    n_calibrated++;
                end
            end
            default: ;
        endcase
    endfunction

    task check_result(imu_corr_t got);
        imu_corr_t want;
        if (corr_q.size() == 0)
        begin
            report($sformatf("result %h arrived with nothing expected", got));
            return;
        end
        want = corr_q.pop_front();
        n_checked++;
        for (int i = 0; i < AXES; i++)
        begin
            if (got.axis[i] !== want.axis[i])
                report($sformatf("result %0d axis %0d: got %h, expected %h",
                                 n_checked, i, got.axis[i], want.axis[i]));
        end
        if (got.phase !== want.phase)
            report($sformatf("result %0d phase: got %0d, expected %0d",
                             n_checked, got.phase, want.phase));
    endtask

    task check_readback(logic [REG_IDX_W-1:0] idx, logic [APB_W-1:0] got);
        logic [APB_W-1:0] want;
        logic [APB_W-1:0] mask;
        case (idx)
            REG_STILL_THR:
            begin
                want = APB_W'(thr_reg);
                mask = 32'hFFFF;
            end
            REG_STILL_CNT:
            begin
                want = APB_W'(cnt_reg);
                mask = 32'hFF;
            end
            default:
            begin
                want = APB_W'(grav_reg);
                mask = 32'hFFFF;
            end
        endcase
        if ((got & mask) !== (want & mask))
            report($sformatf("register %0d reads %h, expected %h", idx, got, want & mask));
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS = 1250;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PRE_THR [4]  = '{0, 65535, 10, 7};
    localparam int PRE_CNT [4]  = '{1, 255, 0, 3};
    localparam int PRE_GRAV [4] = '{-32768, 32767, 0, 16383};

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [AXES*DATA_W-1:0]      s_axis_tdata;
    logic                        s_axis_tuser;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [AXES*DATA_W-1:0]      m_axis_tdata;
    logic [PHASE_W-1:0]          m_axis_tuser;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [APB_W-1:0]            pwdata;
    logic [APB_W-1:0]            prdata;
    logic                        pready;

    bias_scoreboard              sb;
    bit                          tx_fast;
    logic [REG_IDX_W-1:0]        all_regs [3] = '{REG_STILL_THR, REG_STILL_CNT, REG_GRAVITY};

    imu_bias_calibrator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 4 ns clock
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin : result_sink
        int        rx_wait;
        bit        rx_fast;
        bit        held;
        imu_corr_t got;
        m_axis_tready = 0;
        rx_wait       = 0;
        rx_fast       = 0;
        held          = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= (rx_wait == 0);
            if (rx_wait > 0)
                rx_wait--;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.axis  = m_axis_tdata;
                got.phase = m_axis_tuser;
                sb.check_result(got);
                if ($urandom_range(0, 39) == 0)
                    rx_fast = !rx_fast;
                rx_wait = rx_fast ? 0 : $urandom_range(0, 13);
                if (!held && sb.n_noted >= 300)
                begin
                    rx_wait = 400;
                    held    = 1;
                end
            end
        end
    end

    // offer one sample after a random gap and wait for the request to be taken
    task automatic push_sample(imu_sample_t smp);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 39) == 0)
            tx_fast = !tx_fast;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= smp.axis;
        s_axis_tuser  <= smp.recal;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample(smp);
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_W-1:0] val);
        @(negedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic apb_read(input logic [REG_IDX_W-1:0] idx, output logic [APB_W-1:0] val);
        @(negedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        val = prdata;
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
    endtask

    // write all three registers while idle and read them back
    task automatic apply_config(int thr, int cnt, int grav);
        logic [APB_W-1:0] rd;
        wait_drained();
        apb_write(REG_STILL_THR, thr);
        apb_write(REG_STILL_CNT, cnt);
        apb_write(REG_GRAVITY, grav);
        foreach (all_regs[r])
        begin
            apb_read(all_regs[r], rd);
            sb.check_readback(all_regs[r], rd);
        end
    endtask

    function automatic imu_sample_t mk(int gx, int gy, int gz, int ax, int ay, int az, bit rc);
        imu_sample_t smp;
        smp.axis[0] = gx[DATA_W-1:0];
        smp.axis[1] = gy[DATA_W-1:0];
        smp.axis[2] = gz[DATA_W-1:0];
        smp.axis[3] = ax[DATA_W-1:0];
        smp.axis[4] = ay[DATA_W-1:0];
        smp.axis[5] = az[DATA_W-1:0];
        smp.recal   = rc;
        return smp;
    endfunction

    // full-range sample leaning toward the corners
    function automatic imu_sample_t rand_sample();
        imu_sample_t smp;
        for (int i = 0; i < AXES; i++)
        begin
            case ($urandom_range(0, 11))
                0:       smp.axis[i] = 16'h8000;
                1:       smp.axis[i] = 16'h7FFF;
                2:       smp.axis[i] = 16'hFFFF;
                3:       smp.axis[i] = 16'h0000;
                default: smp.axis[i] = DATA_W'($urandom_range(0, 65535));
            endcase
        end
        smp.recal = 0;
        return smp;
    endfunction

    // recalibrate, hold still until averaging starts, fill the window, then a few corrected
    task automatic calibration_run(bit extreme);
        imu_sample_t     smp;
        int              lim;
        int              nv;
        int              delta;
        int              guard;
        bit [AXES-1:0]   pol;
        pol       = AXES'($urandom_range(0, 63));
        smp       = rand_sample();
        smp.recal = 1;
        push_sample(smp);
        // drift inside the threshold with the odd jolt
        guard = 0;
        while (sb.phase == PH_WAIT && guard < 1000)
        begin
            smp = rand_sample();
            if ($urandom_range(0, 19) != 0)
            begin
                lim = (sb.thr_reg < 300) ? int'(sb.thr_reg) : 300;
                for (int i = 0; i < GYRO_AXES; i++)
                begin
                    delta = int'($urandom_range(0, 2 * lim)) - lim;
                    nv    = int'(sb.prev_gyro[i]) + delta;
                    if (nv > 32767 || nv < -32768)
                        nv = int'(sb.prev_gyro[i]) - delta;
                    smp.axis[i] = nv[DATA_W-1:0];
                end
            end
            push_sample(smp);
            guard++;
        end
        // averaging window, rarely cut short by a recalibrate
        while (sb.phase == PH_AVG)
        begin
            smp = rand_sample();
            if (extreme)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    smp.axis[i] = pol[i] ? 16'h7FFF : 16'h8000;
                end
            end
            smp.recal = ($urandom_range(0, 399) == 0);
            push_sample(smp);
        end
        repeat ($urandom_range(2, 12)) push_sample(rand_sample());
    endtask

    task automatic noise_burst();
        imu_sample_t smp;
        repeat ($urandom_range(5, 30))
        begin
            smp       = rand_sample();
            smp.recal = ($urandom_range(0, 14) == 0);
            push_sample(smp);
        end
    endtask

    initial
    begin : stimulus
        int ep;
        int thr;
        int cnt;
        int grav;
        sb            = new();
        tx_fast       = 0;
        rst_n         = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 0;
        psel          = 0;
        penable       = 0;
        pwrite        = 0;
        paddr         = '0;
        pwdata        = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // priming sample, field extremes, threshold edges at the reset threshold
        push_sample(mk(0, 0, 0, 0, 0, 0, 0));
        push_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 0));
        push_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0));
        push_sample(mk(-32758, -32758, -32758, 21845, -21846, 0, 0));
        push_sample(mk(-32747, -32758, -32758, -1, 1, -1, 0));
        push_sample(mk(-32737, -32768, -32758, 100, -100, 16383, 0));
        push_sample(mk(-32737, -32768, -32747, 0, 0, 0, 0));
        // recalibrate twice in a row, each one a fresh priming sample
        push_sample(mk(1234, -5678, 42, 32767, -32768, -16383, 1));
        push_sample(mk(-32768, 32767, 0, 0, 0, 0, 1));
        for (int k = 1; k <= 4; k++)
        begin
            push_sample(mk(-32768 + 10 * k, 32767 - 10 * k, 0, k, -k, 16383, 0));
        end
        push_sample(mk(-32728, 32727, 11, -1, -1, -1, 0));

        // preset extremes first (count change mid wait, count of zero), then random setups
        for (ep = 0; ep < 4 || sb.n_noted < ITEMS; ep++)
        begin
            if (ep < 4)
                apply_config(PRE_THR[ep], PRE_CNT[ep], PRE_GRAV[ep]);
            else if ($urandom_range(0, 2) == 0)
            begin
                thr = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 0 : 65535)
                                                  : $urandom_range(0, 60);
                cnt = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 40);
                grav = $urandom_range(0, 1) ? 16383 : int'($urandom_range(0, 65535)) - 32768;
                apply_config(thr, cnt, grav);
            end
            if (ep == 0)
                apb_write(REG_SPARE, $urandom());
            if (ep >= 4 && $urandom_range(0, 3) == 0)
                noise_burst();
            else
                calibration_run(ep < 2 || $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                noise_burst();
        end

        wait_drained();
        repeat (20) @(negedge clk);
        $display("covered %0d samples, %0d completed calibrations, %0d register writes",
                 sb.n_noted, sb.n_calibrated, sb.n_writes);
        $display("compared %0d results, %0d mismatches", sb.n_checked, sb.n_fail);
        if (sb.n_fail == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
